// ===== rtl/pidaw_pkg.sv =====
// Shared types, constants and register codes of the PID controller block.
package pidaw_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned WORD_BITS_DEF = 32;

  localparam int unsigned CFG_ADDR_W = 5;

  typedef enum logic [2:0] {
    REG_GAIN_P      = 3'd0,
    REG_GAIN_I      = 3'd1,
    REG_GAIN_D      = 3'd2,
    REG_GAIN_AW     = 3'd3,
    REG_FILTER_TC   = 3'd4,
    REG_OUTPUT_MAX  = 3'd5,
    REG_OUTPUT_MIN  = 3'd6,
    REG_RATE_LIMIT  = 3'd7
  } cfg_reg_e;

  localparam logic [31:0] OUTPUT_MAX_RST = 32'h7FFF_FFFF;
  localparam logic [31:0] OUTPUT_MIN_RST = 32'h8000_0000;
  localparam logic [30:0] RATE_LIMIT_RST = 31'h7FFF_FFFF;
  localparam logic [9:0]  MS_PER_S       = 10'd1000;

  typedef enum logic [3:0] {
    OP_DT,
    OP_GI,
    OP_GI_DT,
    OP_AW,
    OP_AW_DT,
    OP_TC,
    OP_DIV,
    OP_GP,
    OP_GD,
    OP_RATE
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LAUNCH,
    ST_WAIT,
    ST_PUBLISH
  } state_e;

  typedef struct packed {
    logic [31:0] gain_p;
    logic [31:0] gain_i;
    logic [31:0] gain_d;
    logic [31:0] gain_aw;
    logic [30:0] filter_tc;
    logic [31:0] output_max;
    logic [31:0] output_min;
    logic [30:0] rate_limit;
  } cfg_t;

  typedef struct packed {
    logic accept;
    logic launch;
    logic publish;
    op_e  op;
  } ctrl_cmd_t;

  typedef struct packed {
    logic unit_done;
    logic same_time;
    logic slot_free;
  } ctrl_sts_t;

endpackage

// ===== rtl/pidaw_mul.sv =====
// Saturating fixed-point multiplier built from four half-width partial products.
module pidaw_mul import pidaw_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF,
  parameter int unsigned WORD_BITS = WORD_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [WORD_BITS-1:0] a_i,
  input  logic [WORD_BITS-1:0] b_i,
  output logic                 done_o,
  output logic [WORD_BITS-1:0] res_o
);

  localparam int unsigned W  = WORD_BITS;
  localparam int unsigned L  = (W + 1) / 2;
  localparam int unsigned PW = 2 * W;
  localparam logic [PW-1:0] LIM  = {{W{1'b0}}, 1'b1, {(W-1){1'b0}}};
  localparam logic [PW-1:0] WMAX = LIM - PW'(1);

  logic [W-1:0]  x_q, y_q;
  logic          neg_q;
  logic [PW-1:0] acc_q;
  logic [1:0]    cnt_q;
  logic          busy_q, done_q;

  logic [L-1:0]   xs, ys;
  logic [2*L-1:0] prod;
  logic [PW-1:0]  pe, addend, q;

  always_comb begin
    xs = cnt_q[0] ? L'(x_q >> L) : x_q[L-1:0];
    ys = cnt_q[1] ? L'(y_q >> L) : y_q[L-1:0];
    prod = xs * ys;
    pe = {{(PW-2*L){1'b0}}, prod};
    case (cnt_q)
      2'd0:    addend = pe;
      2'd3:    addend = pe << (2 * L);
      default: addend = pe << L;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      done_q <= busy_q && (cnt_q == 2'd3);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 2'd0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 2'd1;
        if (cnt_q == 2'd3) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q   <= a_i[W-1] ? W'(-a_i) : a_i;
      y_q   <= b_i[W-1] ? W'(-b_i) : b_i;
      neg_q <= a_i[W-1] ^ b_i[W-1];
      acc_q <= '0;
    end else if (busy_q) begin
      acc_q <= acc_q + addend;
    end
  end

  // drop the fraction bits, then clamp the magnitude to the word range
  always_comb begin
    q = acc_q >> FRAC_BITS;
    if (neg_q) begin
      res_o = (q > LIM) ? LIM[W-1:0] : W'(-q[W-1:0]);
    end else begin
      res_o = (q > WMAX) ? WMAX[W-1:0] : q[W-1:0];
    end
  end

  assign done_o = done_q;

endmodule

// ===== rtl/pidaw_div.sv =====
// Bit-serial restoring divider with a saturated signed quotient.
module pidaw_div import pidaw_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF,
  parameter int unsigned WORD_BITS = WORD_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [((WORD_BITS > 32) ? WORD_BITS : 32) + FRAC_BITS - 1:0] num_i,
  input  logic [WORD_BITS-1:0]      den_i,
  input  logic                      neg_i,
  output logic                      done_o,
  output logic [WORD_BITS-1:0]      res_o
);

  localparam int unsigned W  = WORD_BITS;
  localparam int unsigned DW = ((W > 32) ? W : 32) + FRAC_BITS;
  localparam int unsigned CW = $clog2(DW);
  localparam logic [DW-1:0] LIM  = {{(DW-W){1'b0}}, 1'b1, {(W-1){1'b0}}};
  localparam logic [DW-1:0] WMAX = LIM - DW'(1);

  logic [DW-1:0] quo_q;
  logic [W-1:0]  rem_q, den_q;
  logic          neg_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q, done_q;

  logic [W:0] rem_sh, den_e;
  logic       fits;

  always_comb begin
    rem_sh = {rem_q, quo_q[DW-1]};
    den_e  = {1'b0, den_q};
    fits   = rem_sh >= den_e;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CW'(DW - 1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CW'(1);
        if (cnt_q == CW'(DW - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
      neg_q <= neg_i;
    end else if (busy_q) begin
      rem_q <= fits ? W'(rem_sh - den_e) : rem_sh[W-1:0];
      quo_q <= {quo_q[DW-2:0], fits};
    end
  end

  // a zero divisor yields an all-ones quotient, which clamps to full scale
  always_comb begin
    if (neg_q) begin
      res_o = (quo_q > LIM) ? LIM[W-1:0] : W'(-quo_q[W-1:0]);
    end else begin
      res_o = (quo_q > WMAX) ? WMAX[W-1:0] : quo_q[W-1:0];
    end
  end

  assign done_o = done_q;

endmodule

// ===== rtl/pidaw_datapath.sv =====
// Datapath: controller state, operand selection, shared multiplier and the divider.
module pidaw_datapath import pidaw_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF,
  parameter int unsigned WORD_BITS = WORD_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  ctrl_cmd_t   cmd_i,
  output ctrl_sts_t   sts_o,
  input  logic [31:0] measured_value_i,
  input  logic [31:0] target_value_i,
  input  logic [31:0] time_ms_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] drive_value_o
);

  localparam int unsigned W  = WORD_BITS;
  localparam int unsigned DW = ((W > 32) ? W : 32) + FRAC_BITS;
  localparam int unsigned EW = ((W > 33) ? W : 33) + 2;
  localparam logic [EW-1:0] WMAX_E = {{(EW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic [EW-1:0] WMIN_E = ~WMAX_E;
  localparam logic [EW-1:0] OMAX_E = {{(EW-31){1'b0}}, {31{1'b1}}};
  localparam logic [EW-1:0] OMIN_E = ~OMAX_E;

  // reciprocal of 1000 (shift 38) and of 125 (shift 35), exact over 32 bits
  localparam logic [31:0] DT_RECIP      = 32'd274877907;
  localparam int unsigned DT_SHIFT_MS   = 38;
  localparam int unsigned DT_SHIFT_FRAC = 35;

  function automatic logic [EW-1:0] ext_w(input logic [W-1:0] v);
    return {{(EW-W){v[W-1]}}, v};
  endfunction

  function automatic logic [W-1:0] sat_e(input logic [EW-1:0] v);
    logic [W-1:0] r;
    if ($signed(v) > $signed(WMAX_E)) begin
      r = WMAX_E[W-1:0];
    end else if ($signed(v) < $signed(WMIN_E)) begin
      r = WMIN_E[W-1:0];
    end else begin
      r = v[W-1:0];
    end
    return r;
  endfunction

  function automatic logic [W-1:0] sat32(input logic [31:0] v);
    return sat_e({{(EW-32){v[31]}}, v});
  endfunction

  function automatic logic [W-1:0] sat31(input logic [30:0] v);
    return sat_e({{(EW-31){1'b0}}, v});
  endfunction

  function automatic logic [W-1:0] add_sat(input logic [W-1:0] a, input logic [W-1:0] b);
    return sat_e(ext_w(a) + ext_w(b));
  endfunction

  function automatic logic [W-1:0] sub_sat(input logic [W-1:0] a, input logic [W-1:0] b);
    return sat_e(ext_w(a) - ext_w(b));
  endfunction

  function automatic logic [W-1:0] mag(input logic [W-1:0] v);
    return v[W-1] ? W'(-v) : v;
  endfunction

  logic [31:0]  now_q, last_time_q;
  logic [W-1:0] err_q, dt_q, t1_q, t2_q;
  logic [W-1:0] integ_q, perr_q, pder_q, prc_q, pout_q;
  logic [31:0]  out_q;
  logic         out_valid_q;

  logic [3:0]   dt_stage_q;
  logic [31:0]  diff_q;
  logic [22:0]  q1_q;
  logic [9:0]   r1_q;
  logic [23:0]  q2_q;

  logic [W-1:0]  gp, gi, gd, gaw, tc, hi, lo, rate;
  logic          use_div, use_mul, mul_start, div_start;
  logic [W-1:0]  mul_a, mul_b, den, num_w, div_den;
  logic [DW-1:0] div_num;
  logic          div_neg;
  logic          mul_done, div_done, dt_go, dt_done, unit_done;
  logic [W-1:0]  mul_res, div_res;
  logic [W-1:0]  raw, clamped, up, dn;
  logic [EW-1:0] pout_e;
  logic [63:0]   dt_p1, dt_p2, dt_full;
  logic [31:0]   dt_y;
  logic [W-1:0]  dt_sat;

  always_comb begin
    gp   = sat32(cfg_i.gain_p);
    gi   = sat32(cfg_i.gain_i);
    gd   = sat32(cfg_i.gain_d);
    gaw  = sat32(cfg_i.gain_aw);
    tc   = sat31(cfg_i.filter_tc);
    hi   = sat32(cfg_i.output_max);
    lo   = sat32(cfg_i.output_min);
    rate = sat31(cfg_i.rate_limit);
  end

  // operand select for the op being launched
  always_comb begin
    mul_a   = gi;
    mul_b   = err_q;
    num_w   = t1_q;
    den     = add_sat(dt_q, tc);
    div_num = '0;
    div_den = '0;
    div_neg = 1'b0;
    use_div = 1'b0;
    use_mul = 1'b1;
    case (cmd_i.op)
      OP_DT: begin
        use_mul = 1'b0;
      end
      OP_GI: begin
        mul_a = gi;
        mul_b = err_q;
      end
      OP_GI_DT: begin
        mul_a = t1_q;
        mul_b = dt_q;
      end
      OP_AW: begin
        mul_a = gaw;
        mul_b = sub_sat(pout_q, prc_q);
      end
      OP_AW_DT: begin
        mul_a = t2_q;
        mul_b = dt_q;
      end
      OP_TC: begin
        mul_a = tc;
        mul_b = pder_q;
      end
      OP_DIV: begin
        use_div = 1'b1;
        use_mul = 1'b0;
        div_num = DW'({mag(num_w), {FRAC_BITS{1'b0}}});
        div_den = mag(den);
        div_neg = num_w[W-1] ^ den[W-1];
      end
      OP_GP: begin
        mul_a = gp;
        mul_b = err_q;
      end
      OP_GD: begin
        mul_a = gd;
        mul_b = pder_q;
      end
      OP_RATE: begin
        mul_a = rate;
        mul_b = dt_q;
      end
      default: begin
        mul_a = gi;
      end
    endcase
    mul_start = cmd_i.launch && use_mul;
    div_start = cmd_i.launch && use_div;
    dt_go     = cmd_i.launch && (cmd_i.op == OP_DT);
  end

  pidaw_mul #(
    .FRAC_BITS(FRAC_BITS),
    .WORD_BITS(WORD_BITS)
  ) u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mul_start),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .done_o (mul_done),
    .res_o  (mul_res)
  );

  pidaw_div #(
    .FRAC_BITS(FRAC_BITS),
    .WORD_BITS(WORD_BITS)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .neg_i  (div_neg),
    .done_o (div_done),
    .res_o  (div_res)
  );

  // dt = floor(diff * 2^FRAC_BITS / 1000): split diff into whole seconds and
  // leftover milliseconds, divide each by reciprocal multiplication
  always_comb begin
    dt_p1   = 64'(diff_q) * 64'(DT_RECIP);
    dt_y    = 32'(r1_q) << (FRAC_BITS - 3);
    dt_p2   = 64'(dt_y) * 64'(DT_RECIP);
    dt_full = (64'(q1_q) << FRAC_BITS) + 64'(q2_q);
    if (dt_full > 64'(WMAX_E)) begin
      dt_sat = WMAX_E[W-1:0];
    end else begin
      dt_sat = dt_full[W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dt_stage_q <= '0;
    end else begin
      dt_stage_q <= {dt_stage_q[2:0], dt_go};
    end
  end

  always_ff @(posedge clk_i) begin
    if (dt_go) begin
      diff_q <= now_q - last_time_q;
    end
    if (dt_stage_q[0]) begin
      q1_q <= dt_p1[DT_SHIFT_MS +: 23];
    end
    if (dt_stage_q[1]) begin
      r1_q <= 10'(diff_q - 32'(q1_q) * 32'(MS_PER_S));
    end
    if (dt_stage_q[2]) begin
      q2_q <= 24'(dt_p2 >> DT_SHIFT_FRAC);
    end
  end

  assign dt_done   = dt_stage_q[3];
  assign unit_done = mul_done || div_done || dt_done;

  // command assembly: raw sum, clamp window, slew window
  always_comb begin
    raw = add_sat(add_sat(t2_q, integ_q), mul_res);
    if ($signed(raw) > $signed(hi)) begin
      clamped = hi;
    end else if ($signed(raw) < $signed(lo)) begin
      clamped = lo;
    end else begin
      clamped = raw;
    end
    up = add_sat(pout_q, mul_res);
    dn = sub_sat(pout_q, mul_res);
    pout_e = ext_w(pout_q);
  end

  logic [31:0] drive_next;
  always_comb begin
    if ($signed(pout_e) > $signed(OMAX_E)) begin
      drive_next = OMAX_E[31:0];
    end else if ($signed(pout_e) < $signed(OMIN_E)) begin
      drive_next = OMIN_E[31:0];
    end else begin
      drive_next = pout_e[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_time_q <= '0;
      integ_q     <= '0;
      perr_q      <= '0;
      pder_q      <= '0;
      prc_q       <= '0;
      pout_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.publish && sts_o.slot_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (unit_done) begin
        case (cmd_i.op)
          OP_DT:    last_time_q <= now_q;
          OP_AW_DT: integ_q <= add_sat(integ_q, add_sat(t1_q, mul_res));
          OP_DIV: begin
            // a zero numerator gives zero even over a zero denominator
            pder_q <= (num_w == '0) ? '0 : div_res;
            perr_q <= err_q;
          end
          OP_GD:    prc_q <= raw;
          OP_RATE: begin
            if ($signed(t1_q) > $signed(up)) begin
              pout_q <= up;
            end else if ($signed(t1_q) < $signed(dn)) begin
              pout_q <= dn;
            end else begin
              pout_q <= t1_q;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      now_q <= time_ms_i;
      err_q <= sub_sat(sat32(target_value_i), sat32(measured_value_i));
    end
    if (unit_done) begin
      case (cmd_i.op)
        OP_DT:    dt_q <= dt_sat;
        OP_GI:    t1_q <= mul_res;
        OP_GI_DT: t1_q <= mul_res;
        OP_AW:    t2_q <= mul_res;
        OP_TC:    t1_q <= add_sat(sub_sat(err_q, perr_q), mul_res);
        OP_GP:    t2_q <= mul_res;
        OP_GD:    t1_q <= clamped;
        default: begin
        end
      endcase
    end
    if (cmd_i.publish && sts_o.slot_free) begin
      out_q <= drive_next;
    end
  end

  always_comb begin
    sts_o.unit_done = unit_done;
    sts_o.same_time = (time_ms_i == last_time_q);
    sts_o.slot_free = !out_valid_q || !out_stall_i;
  end

  assign out_valid_o   = out_valid_q;
  assign drive_value_o = out_q;

endmodule

// ===== rtl/pidaw_ctrl.sv =====
// Sequencer: walks one item through the op list and hands out the result.
module pidaw_ctrl import pidaw_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  ctrl_sts_t sts_i,
  output ctrl_cmd_t cmd_o
);

  state_e state_q, state_d;
  op_e    op_q, op_d;

  function automatic op_e next_op(input op_e op);
    op_e r;
    unique case (op)
      OP_DT:    r = OP_GI;
      OP_GI:    r = OP_GI_DT;
      OP_GI_DT: r = OP_AW;
      OP_AW:    r = OP_AW_DT;
      OP_AW_DT: r = OP_TC;
      OP_TC:    r = OP_DIV;
      OP_DIV:   r = OP_GP;
      OP_GP:    r = OP_GD;
      OP_GD:    r = OP_RATE;
      default:  r = OP_DT;
    endcase
    return r;
  endfunction

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (sts_i.same_time) begin
            state_d = ST_PUBLISH;
          end else begin
            state_d = ST_LAUNCH;
            op_d    = OP_DT;
          end
        end
      end
      ST_LAUNCH: state_d = ST_WAIT;
      ST_WAIT: begin
        if (sts_i.unit_done) begin
          if (op_q == OP_RATE) begin
            state_d = ST_PUBLISH;
          end else begin
            state_d = ST_LAUNCH;
            op_d    = next_op(op_q);
          end
        end
      end
      ST_PUBLISH: begin
        if (sts_i.slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o    = (state_q != ST_IDLE);
    cmd_o.accept  = in_valid_i && (state_q == ST_IDLE);
    cmd_o.launch  = (state_q == ST_LAUNCH);
    cmd_o.publish = (state_q == ST_PUBLISH);
    cmd_o.op      = op_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      op_q    <= OP_DT;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
    end
  end

endmodule

// ===== rtl/pid_antiwindup_rate_limited.sv =====
// Top level: PID controller with back-calculation anti-windup and rate limit.
//
// One beat in gives one beat out. Each input beat carries a measurement,
// a setpoint and a millisecond timestamp; the block derives dt from the
// wrapped timestamp difference, updates the integral (with anti-windup
// feedback from the last clamp), runs a filtered derivative, sums the
// terms, clamps the command to output_min/output_max and limits its slew
// to rate_limit*dt. All internal values are signed fixed point, WORD_BITS
// wide with FRAC_BITS fraction bits, and every step saturates. A beat whose
// timestamp equals the last accepted one repeats the previous command and
// leaves state untouched. Any other beat runs the full sequence: the beat
// is taken, dt comes from a reciprocal multiplication by 1/1000, one
// bit-serial divider forms the derivative at one quotient bit per cycle,
// one shared multiplier runs eight products at four partial products
// each, and the result is published. One beat is in flight at a time; a
// new beat is taken while the previous result still waits in the output
// register. Registers are to be written over the APB-style port only
// while idle; the block itself does not enforce this.
module pid_antiwindup_rate_limited import pidaw_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF,
  parameter int unsigned WORD_BITS = WORD_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [31:0]           measured_value_i,
  input  logic [31:0]           target_value_i,
  input  logic [31:0]           time_ms_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [31:0]           drive_value_o
);

  cfg_t      cfg_q;
  ctrl_cmd_t cmd;
  ctrl_sts_t sts;
  cfg_reg_e  reg_sel;
  logic      cfg_wr;

  assign pready  = 1'b1;
  assign reg_sel = cfg_reg_e'(paddr[CFG_ADDR_W-1:2]);
  assign cfg_wr  = psel && penable && pwrite;

  // register file: write on the access phase, reset to the documented values
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_p     <= '0;
      cfg_q.gain_i     <= '0;
      cfg_q.gain_d     <= '0;
      cfg_q.gain_aw    <= '0;
      cfg_q.filter_tc  <= '0;
      cfg_q.output_max <= OUTPUT_MAX_RST;
      cfg_q.output_min <= OUTPUT_MIN_RST;
      cfg_q.rate_limit <= RATE_LIMIT_RST;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_GAIN_P:     cfg_q.gain_p     <= pwdata;
        REG_GAIN_I:     cfg_q.gain_i     <= pwdata;
        REG_GAIN_D:     cfg_q.gain_d     <= pwdata;
        REG_GAIN_AW:    cfg_q.gain_aw    <= pwdata;
        REG_FILTER_TC:  cfg_q.filter_tc  <= pwdata[30:0];
        REG_OUTPUT_MAX: cfg_q.output_max <= pwdata;
        REG_OUTPUT_MIN: cfg_q.output_min <= pwdata;
        REG_RATE_LIMIT: cfg_q.rate_limit <= pwdata[30:0];
        default: begin
        end
      endcase
    end
  end

  // readback, unsigned registers zero-extended
  always_comb begin
    unique case (reg_sel)
      REG_GAIN_P:     prdata = cfg_q.gain_p;
      REG_GAIN_I:     prdata = cfg_q.gain_i;
      REG_GAIN_D:     prdata = cfg_q.gain_d;
      REG_GAIN_AW:    prdata = cfg_q.gain_aw;
      REG_FILTER_TC:  prdata = {1'b0, cfg_q.filter_tc};
      REG_OUTPUT_MAX: prdata = cfg_q.output_max;
      REG_OUTPUT_MIN: prdata = cfg_q.output_min;
      REG_RATE_LIMIT: prdata = {1'b0, cfg_q.rate_limit};
      default:        prdata = '0;
    endcase
  end

  pidaw_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  pidaw_datapath #(
    .FRAC_BITS(FRAC_BITS),
    .WORD_BITS(WORD_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .measured_value_i(measured_value_i),
    .target_value_i  (target_value_i),
    .time_ms_i       (time_ms_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .drive_value_o   (drive_value_o)
  );

endmodule
